// ----- rtl/mams_pkg.sv -----
// ----------------------------------------------------------------------------
// mams_pkg
// Shared types, register map and reset values for the deinterlace mode
// selector.
// ----------------------------------------------------------------------------
package mams_pkg;

   localparam int DIFF_W  = 32;
   localparam int STH_W   = 13;
   localparam int MTH_W   = 14;
   localparam int RUN_W   = 10;
   localparam int MODE_W  = 7;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

   localparam logic [STH_W-1:0]  STATIC_THR_RST  = STH_W'(15);
   localparam logic [MTH_W-1:0]  MOTION_THR_RST  = MTH_W'(900);
   localparam logic [RUN_W-1:0]  STATIC_CNT_RST  = RUN_W'(100);
   localparam logic [RUN_W-1:0]  LOW_CNT_RST     = RUN_W'(4);
   localparam logic [MODE_W-1:0] STATIC_MODE_RST = MODE_W'(0);
   localparam logic [MODE_W-1:0] LOW_MODE_RST    = MODE_W'(1);
   localparam logic [MODE_W-1:0] HIGH_MODE_RST   = MODE_W'(1);

   // register index, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_STATIC_THR  = 3'd0,
      REG_MOTION_THR  = 3'd1,
      REG_STATIC_CNT  = 3'd2,
      REG_LOW_CNT     = 3'd3,
      REG_STATIC_MODE = 3'd4,
      REG_LOW_MODE    = 3'd5,
      REG_HIGH_MODE   = 3'd6,
      REG_UNUSED      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [STH_W-1:0]  static_thr;
      logic [MTH_W-1:0]  motion_thr;
      logic [RUN_W-1:0]  static_cnt;
      logic [RUN_W-1:0]  low_cnt;
      logic [MODE_W-1:0] static_mode;
      logic [MODE_W-1:0] low_mode;
      logic [MODE_W-1:0] high_mode;
   } cfg_type;

   function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] v);
      return (v == RUN_MAX) ? v : v + RUN_W'(1);
   endfunction

endpackage

// ----- rtl/motion_adaptive_mode_selector_core.sv -----
// ----------------------------------------------------------------------------
// motion_adaptive_mode_selector_core
// Picks a deinterlace mode per video field from a motion measure, with
// hysteresis over runs of static and low-motion fields.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per video field (field_diff, history_ok), valid/ready.
//   rsp_*  : one beat per field (mode_index, processed, mode_changed).
//   csr_*  : APB-style register port, register i at byte address 4*i.
//            The user must write registers only while no field is in flight;
//            the block itself does not enforce this.
// From the req beat to the rsp beat a field lands in an input register,
// the decision logic reads it together with the mode and run counters, and
// the result goes to the output register as the state updates in the same edge.
// One field per cycle unless rsp_ready stalls; the only loop is the mode/counter state.
// When rsp_ready is low the result holds in the output register, one more
// field waits in the input register, and req_ready then drops.
// Reset (synchronous, active high) restores register defaults, empties both
// stages and rearms the start-up: the first field after reset loads the
// high-motion mode, clears the counters and reports a mode change.
// ----------------------------------------------------------------------------
module motion_adaptive_mode_selector_core (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mams_pkg::DIFF_W-1:0]        req_field_diff,
   input  logic                               req_history_ok,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mams_pkg::MODE_W-1:0]        rsp_mode_index,
   output logic                               rsp_processed,
   output logic                               rsp_mode_changed,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mams_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [mams_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [mams_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   mams_pkg::cfg_type                   cfg_ff, cfg_in;
   mams_pkg::reg_index_type             csr_idx;
   logic                                csr_wr;

   logic                                s1_valid_ff, s1_valid_in;
   logic [mams_pkg::DIFF_W-1:0]         s1_diff_ff;
   logic                                s1_hist_ff;
   logic                                advance;

   logic                                started_ff;
   logic [mams_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic [mams_pkg::RUN_W-1:0]          static_run_ff, static_run_in;
   logic [mams_pkg::RUN_W-1:0]          low_run_ff, low_run_in;
   logic                                changed_in;
   logic [mams_pkg::MODE_W-1:0]         mode_prior;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mams_pkg::MODE_W-1:0]         rsp_mode_ff;
   logic                                rsp_proc_ff;
   logic                                rsp_chg_ff;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = mams_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            mams_pkg::REG_STATIC_THR:  cfg_in.static_thr  = csr_pwdata[mams_pkg::STH_W-1:0];
            mams_pkg::REG_MOTION_THR:  cfg_in.motion_thr  = csr_pwdata[mams_pkg::MTH_W-1:0];
            mams_pkg::REG_STATIC_CNT:  cfg_in.static_cnt  = csr_pwdata[mams_pkg::RUN_W-1:0];
            mams_pkg::REG_LOW_CNT:     cfg_in.low_cnt     = csr_pwdata[mams_pkg::RUN_W-1:0];
            mams_pkg::REG_STATIC_MODE: cfg_in.static_mode = csr_pwdata[mams_pkg::MODE_W-1:0];
            mams_pkg::REG_LOW_MODE:    cfg_in.low_mode    = csr_pwdata[mams_pkg::MODE_W-1:0];
            mams_pkg::REG_HIGH_MODE:   cfg_in.high_mode   = csr_pwdata[mams_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mams_pkg::REG_STATIC_THR:  csr_prdata = mams_pkg::CSR_DW'(cfg_ff.static_thr);
         mams_pkg::REG_MOTION_THR:  csr_prdata = mams_pkg::CSR_DW'(cfg_ff.motion_thr);
         mams_pkg::REG_STATIC_CNT:  csr_prdata = mams_pkg::CSR_DW'(cfg_ff.static_cnt);
         mams_pkg::REG_LOW_CNT:     csr_prdata = mams_pkg::CSR_DW'(cfg_ff.low_cnt);
         mams_pkg::REG_STATIC_MODE: csr_prdata = mams_pkg::CSR_DW'(cfg_ff.static_mode);
         mams_pkg::REG_LOW_MODE:    csr_prdata = mams_pkg::CSR_DW'(cfg_ff.low_mode);
         mams_pkg::REG_HIGH_MODE:   csr_prdata = mams_pkg::CSR_DW'(cfg_ff.high_mode);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.static_thr  <= mams_pkg::STATIC_THR_RST;
         cfg_ff.motion_thr  <= mams_pkg::MOTION_THR_RST;
         cfg_ff.static_cnt  <= mams_pkg::STATIC_CNT_RST;
         cfg_ff.low_cnt     <= mams_pkg::LOW_CNT_RST;
         cfg_ff.static_mode <= mams_pkg::STATIC_MODE_RST;
         cfg_ff.low_mode    <= mams_pkg::LOW_MODE_RST;
         cfg_ff.high_mode   <= mams_pkg::HIGH_MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- handshake ----------------
   // stage 1 moves to the output register when that is empty or draining
   assign advance      = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready    = ~s1_valid_ff | advance;
   assign s1_valid_in  = (req_valid & req_ready) | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   // ---------------- mode decision ----------------
   always_comb begin
      mode_in       = mode_ff;
      static_run_in = static_run_ff;
      low_run_in    = low_run_ff;
      changed_in    = 1'b0;

      if (!started_ff) begin
         mode_in       = cfg_ff.high_mode;
         static_run_in = '0;
         low_run_in    = '0;
         changed_in    = 1'b1;
      end
      mode_prior = mode_in;

      if (s1_hist_ff) begin
         if (s1_diff_ff < mams_pkg::DIFF_W'(cfg_ff.static_thr)) begin
            static_run_in = mams_pkg::run_bump(static_run_in);
            low_run_in    = mams_pkg::run_bump(low_run_in);
            if (mode_in != cfg_ff.static_mode && static_run_in >= cfg_ff.static_cnt) begin
               mode_in = cfg_ff.static_mode;
            end else if (mode_in == cfg_ff.high_mode && low_run_in >= cfg_ff.low_cnt) begin
               mode_in = cfg_ff.low_mode;
            end
         end else if (s1_diff_ff < mams_pkg::DIFF_W'(cfg_ff.motion_thr)) begin
            low_run_in    = mams_pkg::run_bump(low_run_in);
            static_run_in = '0;
            if ((mode_in == cfg_ff.high_mode && low_run_in >= cfg_ff.low_cnt) ||
                mode_in == cfg_ff.static_mode) begin
               mode_in = cfg_ff.low_mode;
            end
         end else begin
            low_run_in    = '0;
            static_run_in = '0;
            mode_in       = cfg_ff.high_mode;
         end
         if (mode_in != mode_prior) begin
            changed_in = 1'b1;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         started_ff    <= 1'b0;
         mode_ff       <= '0;
         static_run_ff <= '0;
         low_run_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            started_ff    <= 1'b1;
            mode_ff       <= mode_in;
            static_run_ff <= static_run_in;
            low_run_ff    <= low_run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_diff_ff <= req_field_diff;
         s1_hist_ff <= req_history_ok;
      end
      if (advance) begin
         rsp_mode_ff <= mode_in;
         rsp_proc_ff <= s1_hist_ff;
         rsp_chg_ff  <= changed_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode_index   = rsp_mode_ff;
   assign rsp_processed    = rsp_proc_ff;
   assign rsp_mode_changed = rsp_chg_ff;

`ifndef SYNTH
   // static fields also count as low fields, so the static run never leads
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      static_run_ff <= low_run_ff)
      else $error("static run exceeds low run");

   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("start-up flag cleared without reset");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && started_ff)
      else $error("decided field did not reach the output register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && s1_valid_ff |-> !req_ready)
      else $error("input accepted while both stages are full");
`endif

endmodule
